// ===== hdl/edq_pkg.sv =====
// shared types and constants for the deadline queue
`default_nettype none

package edq_pkg;

   // field widths fixed by the interface
   localparam int MODE_W    = 2;
   localparam int APP_W     = 3;
   localparam int TIME_W    = 31;
   localparam int TAG_W     = 16;
   localparam int DL_W      = 32;
   localparam int STATUS_W  = 2;
   localparam int CNT_OUT_W = 7;
   localparam int CSR_IDX_W = 3;

   // operation codes on req_mode
   localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [APP_W-1:0]  app;
      logic [TIME_W-1:0] rise;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH_RD,
      S_PUSH_WR,
      S_POP_RD,
      S_POP_WR,
      S_CNT_RD,
      S_CNT_CMP,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_START,
      DP_READ,
      DP_PUSH_TAIL,
      DP_PUSH_STEP,
      DP_POP,
      DP_COUNT_STEP,
      DP_SET_FULL,
      DP_SET_EMPTY
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic at_end;
      logic below;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/edq_ctrl.sv =====
// sequencer for push, pop and count walks over the queue memory
`default_nettype none

module edq_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [edq_pkg::MODE_W-1:0]  req_mode,
   output logic                             req_ready,
   input  wire edq_pkg::stat_type           stat,
   output edq_pkg::cmd_type                 cmd
);

   edq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.op       = edq_pkg::DP_NONE;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         edq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = edq_pkg::DP_START;
               case (req_mode)
                  edq_pkg::MODE_PUSH:  state_in = edq_pkg::S_PUSH_RD;
                  edq_pkg::MODE_POP:   state_in = edq_pkg::S_POP_RD;
                  edq_pkg::MODE_COUNT: state_in = edq_pkg::S_CNT_RD;
                  default:             state_in = edq_pkg::S_FINISH;
               endcase
            end
         end
         edq_pkg::S_PUSH_RD: begin
            if (stat.full) begin
               cmd.op   = edq_pkg::DP_SET_FULL;
               state_in = edq_pkg::S_FINISH;
            end else if (stat.at_end) begin
               cmd.op   = edq_pkg::DP_PUSH_TAIL;
               state_in = edq_pkg::S_FINISH;
            end else begin
               cmd.op   = edq_pkg::DP_READ;
               state_in = edq_pkg::S_PUSH_WR;
            end
         end
         edq_pkg::S_PUSH_WR: begin
            cmd.op   = edq_pkg::DP_PUSH_STEP;
            state_in = edq_pkg::S_PUSH_RD;
         end
         edq_pkg::S_POP_RD: begin
            if (stat.empty) begin
               cmd.op   = edq_pkg::DP_SET_EMPTY;
               state_in = edq_pkg::S_FINISH;
            end else begin
               cmd.op   = edq_pkg::DP_READ;
               state_in = edq_pkg::S_POP_WR;
            end
         end
         edq_pkg::S_POP_WR: begin
            cmd.op   = edq_pkg::DP_POP;
            state_in = edq_pkg::S_FINISH;
         end
         edq_pkg::S_CNT_RD: begin
            if (stat.at_end) begin
               state_in = edq_pkg::S_FINISH;
            end else begin
               cmd.op   = edq_pkg::DP_READ;
               state_in = edq_pkg::S_CNT_CMP;
            end
         end
         edq_pkg::S_CNT_CMP: begin
            cmd.op = edq_pkg::DP_COUNT_STEP;
            // stop at the first entry that is not strictly earlier
            state_in = stat.below ? edq_pkg::S_CNT_RD : edq_pkg::S_FINISH;
         end
         edq_pkg::S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = edq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = edq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/edq_datapath.sv =====
// queue memory, delay registers, deadline adder, walk pointers and response register
`default_nettype none

module edq_datapath #(
   parameter int QUEUE_DEPTH = 64,
   parameter int APP_COUNT   = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [edq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [edq_pkg::TIME_W-1:0]     csr_wdata,
   input  wire logic [edq_pkg::APP_W-1:0]      req_app_id,
   input  wire logic [edq_pkg::TIME_W-1:0]     req_rise_time,
   input  wire logic [edq_pkg::TAG_W-1:0]      req_request_tag,
   input  wire logic [edq_pkg::DL_W-1:0]       req_query_deadline,
   input  wire edq_pkg::cmd_type               cmd,
   output edq_pkg::stat_type                   stat,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [edq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [edq_pkg::TAG_W-1:0]           rsp_out_tag,
   output logic [edq_pkg::APP_W-1:0]           rsp_out_app,
   output logic [edq_pkg::DL_W-1:0]            rsp_out_deadline,
   output logic [edq_pkg::CNT_OUT_W-1:0]       rsp_early_count,
   output logic [edq_pkg::CNT_OUT_W-1:0]       rsp_occupancy
);

   localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int SW  = AW + 1;
   localparam int AIW = (APP_COUNT > 1) ? $clog2(APP_COUNT) : 1;
   localparam int OW  = edq_pkg::CNT_OUT_W;
   localparam int TW  = edq_pkg::TIME_W;
   localparam int DW  = edq_pkg::DL_W;
   localparam logic [edq_pkg::APP_W:0] APP_LIMIT = (edq_pkg::APP_W + 1)'(APP_COUNT);
   localparam logic [SW-1:0] DEPTH_S   = SW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);

   edq_pkg::entry_type mem [QUEUE_DEPTH];

   logic [TW-1:0]       delay_ff [APP_COUNT];
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [DW-1:0]       target_ff, target_in;
   logic [DW-1:0]       query_ff, query_in;
   logic                ins_ff, ins_in;
   edq_pkg::entry_type  carry_ff, carry_in;
   edq_pkg::entry_type  rd_data_ff;

   logic [edq_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [edq_pkg::TAG_W-1:0]    res_tag_ff, res_tag_in;
   logic [edq_pkg::APP_W-1:0]    res_app_ff, res_app_in;
   logic [DW-1:0]                res_dl_ff, res_dl_in;

   logic [edq_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [edq_pkg::TAG_W-1:0]     rsp_tag_ff;
   logic [edq_pkg::APP_W-1:0]     rsp_app_ff;
   logic [DW-1:0]                 rsp_dl_ff;
   logic [OW-1:0]                 rsp_cnt_ff;
   logic [OW-1:0]                 rsp_occ_ff;

   logic [edq_pkg::APP_W-1:0] dl_app;
   logic [TW-1:0]             dl_rise;
   logic [TW-1:0]             delay_sel;
   logic [DW-1:0]             dl;
   logic                      found;
   logic [SW-1:0]             addr_sum;
   logic [SW-1:0]             addr_wrap;
   logic [AW-1:0]             mem_addr;
   logic                      mem_we;
   logic                      mem_re;

   // one shared deadline adder: the request at accept, the read entry otherwise
   always_comb begin
      if (cmd.op == edq_pkg::DP_START) begin
         dl_app  = req_app_id;
         dl_rise = req_rise_time;
      end else begin
         dl_app  = rd_data_ff.app;
         dl_rise = rd_data_ff.rise;
      end
      delay_sel = ({1'b0, dl_app} < APP_LIMIT) ? delay_ff[dl_app[AIW-1:0]] : '0;
      dl        = {1'b0, dl_rise} + {1'b0, delay_sel};
   end

   // circular slot address: head plus walk index
   always_comb begin
      addr_sum  = SW'(head_ff) + SW'(idx_ff);
      addr_wrap = (addr_sum >= DEPTH_S) ? (addr_sum - DEPTH_S) : addr_sum;
      mem_addr  = addr_wrap[AW-1:0];
   end

   assign found  = ins_ff || (target_ff < dl);
   assign mem_re = (cmd.op == edq_pkg::DP_READ);
   assign mem_we = (cmd.op == edq_pkg::DP_PUSH_TAIL) ||
                   ((cmd.op == edq_pkg::DP_PUSH_STEP) && found);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= carry_ff;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_comb begin
      head_in       = head_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      target_in     = target_ff;
      query_in      = query_ff;
      ins_in        = ins_ff;
      carry_in      = carry_ff;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      res_app_in    = res_app_ff;
      res_dl_in     = res_dl_ff;
      case (cmd.op)
         edq_pkg::DP_START: begin
            idx_in        = '0;
            cnt_in        = '0;
            ins_in        = 1'b0;
            target_in     = dl;
            query_in      = req_query_deadline;
            carry_in.tag  = req_request_tag;
            carry_in.app  = req_app_id;
            carry_in.rise = req_rise_time;
            res_status_in = edq_pkg::ST_DONE;
            res_tag_in    = '0;
            res_app_in    = '0;
            res_dl_in     = '0;
         end
         edq_pkg::DP_PUSH_TAIL: begin
            fill_in = fill_ff + 1'b1;
         end
         edq_pkg::DP_PUSH_STEP: begin
            // once the slot is found, every later entry ripples back by one
            if (found) begin
               carry_in = rd_data_ff;
               ins_in   = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         edq_pkg::DP_POP: begin
            res_tag_in = rd_data_ff.tag;
            res_app_in = rd_data_ff.app;
            res_dl_in  = dl;
            head_in    = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
            fill_in    = fill_ff - 1'b1;
         end
         edq_pkg::DP_COUNT_STEP: begin
            if (dl < query_ff) begin
               cnt_in = cnt_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         edq_pkg::DP_SET_FULL: begin
            res_status_in = edq_pkg::ST_FULL;
         end
         edq_pkg::DP_SET_EMPTY: begin
            res_status_in = edq_pkg::ST_EMPTY;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < APP_COUNT; i++) begin
            delay_ff[i] <= '0;
         end
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && ({1'b0, csr_index} < APP_LIMIT)) begin
            delay_ff[csr_index[AIW-1:0]] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      target_ff     <= target_in;
      query_ff      <= query_in;
      ins_ff        <= ins_in;
      carry_ff      <= carry_in;
      res_status_ff <= res_status_in;
      res_tag_ff    <= res_tag_in;
      res_app_ff    <= res_app_in;
      res_dl_ff     <= res_dl_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_tag_ff    <= res_tag_ff;
         rsp_app_ff    <= res_app_ff;
         rsp_dl_ff     <= res_dl_ff;
         rsp_cnt_ff    <= OW'(cnt_ff);
         rsp_occ_ff    <= OW'(fill_ff);
      end
   end

   assign stat.full     = (fill_ff == DEPTH_C);
   assign stat.empty    = (fill_ff == '0);
   assign stat.at_end   = (idx_ff == fill_ff);
   assign stat.below    = (dl < query_ff);
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_app      = rsp_app_ff;
   assign rsp_out_deadline = rsp_dl_ff;
   assign rsp_early_count  = rsp_cnt_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_C)
      else $error("fill level above queue depth");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("queue memory read and write in one cycle");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == edq_pkg::DP_POP) |-> (fill_ff != '0))
      else $error("pop issued on empty queue");

   a_pop_fill: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == edq_pkg::DP_POP) |=> (fill_ff == $past(fill_ff) - 1'b1))
      else $error("fill level not reduced after pop");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (idx_ff <= fill_ff) && !stat.full)
      else $error("queue write outside held range");

endmodule

`default_nettype wire

// ===== hdl/edf_deadline_queue.sv =====
// top level of the earliest-deadline-first request queue
`default_nettype none

// Holds up to QUEUE_DEPTH requests ordered by deadline (rise time plus the delay register
// of the request's application), front first, in a single-port circular memory. One
// request is handled at a time and every request gives one response. A pop reads and
// removes the front entry, a push walks the held entries, a count walks them from the
// front and stops early at an entry that is not strictly earlier than the query; a full
// queue on push, an empty queue on pop and an unused mode go straight to the response.
// Each walk step reads one memory entry and then compares it (plus a write when entries
// move back). A push to a queue that is not full walks the whole queue to ripple the
// later entries back by one slot. The next request is taken while the previous response
// still waits for rsp_ready; its final state then waits until that response is taken.
// Delay registers must be written through the csr port only while the queue is idle;
// the block itself does not enforce this. No clearing pass is needed at reset.
module edf_deadline_queue #(
   parameter int QUEUE_DEPTH = 64,
   parameter int APP_COUNT   = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [edq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [edq_pkg::TIME_W-1:0]     csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [edq_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [edq_pkg::APP_W-1:0]      req_app_id,
   input  wire logic [edq_pkg::TIME_W-1:0]     req_rise_time,
   input  wire logic [edq_pkg::TAG_W-1:0]      req_request_tag,
   input  wire logic [edq_pkg::DL_W-1:0]       req_query_deadline,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [edq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [edq_pkg::TAG_W-1:0]           rsp_out_tag,
   output logic [edq_pkg::APP_W-1:0]           rsp_out_app,
   output logic [edq_pkg::DL_W-1:0]            rsp_out_deadline,
   output logic [edq_pkg::CNT_OUT_W-1:0]       rsp_early_count,
   output logic [edq_pkg::CNT_OUT_W-1:0]       rsp_occupancy
);

   edq_pkg::cmd_type  cmd;
   edq_pkg::stat_type stat;

   edq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   edq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .APP_COUNT   (APP_COUNT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_app_id         (req_app_id),
      .req_rise_time      (req_rise_time),
      .req_request_tag    (req_request_tag),
      .req_query_deadline (req_query_deadline),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_out_tag        (rsp_out_tag),
      .rsp_out_app        (rsp_out_app),
      .rsp_out_deadline   (rsp_out_deadline),
      .rsp_early_count    (rsp_early_count),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule

`default_nettype wire
